/* src/mips_mul_div_hilo_unit_defines.svh */
// assertion macros for the multiply/divide unit
`ifndef MIPS_MUL_DIV_HILO_UNIT_DEFINES_SVH
`define MIPS_MUL_DIV_HILO_UNIT_DEFINES_SVH
`define MMD_ASSERT_IMPL(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("lbl failed");
`define MMD_ASSERT_NEXT(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("lbl failed");
`endif

/* src/mmd_pkg.sv */
// package: operation codes, states and shared types
package mmd_pkg;
   localparam int unsigned DataWidth = 64;
   localparam int unsigned OpWidth = 4;
   localparam int unsigned AddrWidth = 2;
   localparam int unsigned CsrWidth = 32;
   localparam logic [AddrWidth-1:0] RegDwordEnable = 2'd0;

   typedef enum logic [OpWidth-1:0] {
      OP_MULT = 4'd0, OP_MULTU = 4'd1, OP_DIV = 4'd2, OP_DIVU = 4'd3,
      OP_DMULT = 4'd4, OP_DMULTU = 4'd5, OP_DDIV = 4'd6, OP_DDIVU = 4'd7,
      OP_MFHI = 4'd8, OP_MFLO = 4'd9, OP_MTHI = 4'd10, OP_MTLO = 4'd11
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001, ST_RUN = 4'b0010, ST_FIX = 4'b0100, ST_OUT = 4'b1000
   } state_type;

   // control from sequencer to the shared shift/add unit
   typedef struct packed {
      logic load;
      logic step;
      logic mul;
   } ctl_type;

   function automatic logic [DataWidth-1:0] sext32(input logic [DataWidth-1:0] x);
      sext32 = {{32{x[31]}}, x[31:0]};
   endfunction
endpackage

/* src/mmd_if.sv */
// handshake channel interfaces
interface mmd_req_if;
   import mmd_pkg::*;
   logic valid;
   logic ready;
   logic [OpWidth-1:0] req_type;
   logic [DataWidth-1:0] operand_a;
   logic [DataWidth-1:0] operand_b;
   modport source(output valid, req_type, operand_a, operand_b, input ready);
   modport sink(input valid, req_type, operand_a, operand_b, output ready);
endinterface

interface mmd_rsp_if;
   import mmd_pkg::*;
   logic valid;
   logic ready;
   logic [DataWidth-1:0] lo_value;
   logic [DataWidth-1:0] hi_value;
   logic [DataWidth-1:0] read_value;
   logic reserved_fault;
   modport source(output valid, lo_value, hi_value, read_value, reserved_fault,
                  input ready);
   modport sink(input valid, lo_value, hi_value, read_value, reserved_fault,
                output ready);
endinterface

/* src/mmd_shift_unit.sv */
// shared shift/add unit: radix-2 unsigned multiply or restoring divide step
module mmd_shift_unit (
   input  logic                         clock,
   input  mmd_pkg::ctl_type             ctl,
   input  logic [mmd_pkg::DataWidth-1:0] load_a,
   input  logic [mmd_pkg::DataWidth-1:0] load_b,
   output logic [mmd_pkg::DataWidth-1:0] acc_hi,
   output logic [mmd_pkg::DataWidth-1:0] acc_lo
);
   import mmd_pkg::*;
   logic [DataWidth-1:0] hi_ff, hi_in, lo_ff, lo_in, b_ff;
   logic [DataWidth:0] sum, diff;

   always_comb begin
      sum = {1'b0, hi_ff} + {1'b0, (lo_ff[0] ? b_ff : '0)};
      diff = {hi_ff, lo_ff[DataWidth-1]} - {1'b0, b_ff};
      hi_in = hi_ff;
      lo_in = lo_ff;
      if (ctl.load) begin
         hi_in = '0;
         lo_in = load_a;
      end else if (ctl.step && ctl.mul) begin
         hi_in = sum[DataWidth:1];
         lo_in = {sum[0], lo_ff[DataWidth-1:1]};
      end else if (ctl.step) begin
         if (!diff[DataWidth]) begin
            hi_in = diff[DataWidth-1:0];
            lo_in = {lo_ff[DataWidth-2:0], 1'b1};
         end else begin
            hi_in = {hi_ff[DataWidth-2:0], lo_ff[DataWidth-1]};
            lo_in = {lo_ff[DataWidth-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      hi_ff <= hi_in;
      lo_ff <= lo_in;
      if (ctl.load) b_ff <= load_b;
   end

   assign acc_hi = hi_ff;
   assign acc_lo = lo_ff;
endmodule

/* src/mips_mul_div_hilo_unit.sv */
// top level: multiply/divide unit with hi/lo registers and apb config port
// moves and faults go straight to the result beat; multiplies and divides take
// 64 steps of the shared shift/add unit plus load, sign fix and output
// throughput: one item at a time, next accepted after the result beat is taken
// reset: hi and lo cleared, dword_enable set, no result pending
module mips_mul_div_hilo_unit (
   input  logic                                clock,
   input  logic                                reset,
   mmd_req_if.sink                             req,
   mmd_rsp_if.source                           rsp,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [mmd_pkg::AddrWidth-1:0]       csr_paddr,
   input  logic [mmd_pkg::CsrWidth-1:0]        csr_pwdata,
   output logic [mmd_pkg::CsrWidth-1:0]        csr_prdata,
   output logic                                csr_pready
);
   import mmd_pkg::*;
   localparam int unsigned CntWidth = $clog2(DataWidth);

   state_type state_ff, state_in;
   logic dw_ff;
   logic [DataWidth-1:0] hi_ff, lo_ff, hi_in, lo_in, rd_ff, rd_in;
   logic flt_ff, flt_in;
   logic [OpWidth-1:0] op_ff;
   logic [DataWidth-1:0] a_ff, b_ff;
   logic neg_q_ff, neg_r_ff, neg_p_ff;
   logic [CntWidth-1:0] cnt_ff;
   ctl_type ctl;
   logic [DataWidth-1:0] ua, ub, acc_hi, acc_lo;
   logic [DataWidth-1:0] ra, rb, sb;
   logic acc;
   logic [2*DataWidth-1:0] prod;
   logic [DataWidth-1:0] q, r;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == RegDwordEnable) ? CsrWidth'(dw_ff) : '0;

   assign acc = req.valid && req.ready;
   assign req.ready = (state_ff == ST_IDLE);
   assign rsp.valid = (state_ff == ST_OUT);
   assign rsp.lo_value = lo_ff;
   assign rsp.hi_value = hi_ff;
   assign rsp.read_value = rd_ff;
   assign rsp.reserved_fault = flt_ff;

   // operand conditioning into unsigned magnitudes
   always_comb begin
      ra = req.operand_a;
      rb = req.operand_b;
      sb = {{29{rb[34]}}, rb[34:0]};
      ua = ra;
      ub = rb;
      unique case (req.req_type)
         OP_MULT:   begin ua = ra[63] ? -ra : ra; ub = sb[63] ? -sb : sb; end
         OP_MULTU:  begin ua = {32'd0, ra[31:0]}; ub = {32'd0, rb[31:0]}; end
         OP_DIV:    begin ua = sext32(ra); ua = ua[63] ? -ua : ua;
                          ub = rb[63] ? -rb : rb; end
         OP_DIVU:   begin ua = {32'd0, ra[31:0]}; ub = {32'd0, rb[31:0]}; end
         OP_DMULT, OP_DDIV: begin ua = ra[63] ? -ra : ra; ub = rb[63] ? -rb : rb; end
         default: ;
      endcase
   end

   mmd_shift_unit u_shift (
      .clock(clock), .ctl(ctl), .load_a(ua), .load_b(ub),
      .acc_hi(acc_hi), .acc_lo(acc_lo)
   );

   always_comb begin
      ctl.load = acc;
      ctl.step = (state_ff == ST_RUN);
      ctl.mul = (op_ff == OP_MULT) || (op_ff == OP_MULTU) || (op_ff == OP_DMULT)
                || (op_ff == OP_DMULTU);
   end

   always_comb begin
      prod = {acc_hi, acc_lo};
      if (neg_p_ff) prod = -prod;
      q = neg_q_ff ? -acc_lo : acc_lo;
      r = neg_r_ff ? -acc_hi : acc_hi;
   end

   always_comb begin
      state_in = state_ff;
      hi_in = hi_ff;
      lo_in = lo_ff;
      rd_in = rd_ff;
      flt_in = flt_ff;
      unique case (state_ff)
         ST_IDLE: if (acc) begin
            rd_in = '0;
            flt_in = 1'b0;
            state_in = ST_OUT;
            priority if (req.req_type[3:2] == 2'b01 && !dw_ff) begin
               flt_in = 1'b1;
            end else if (req.req_type == OP_MFHI) begin
               rd_in = hi_ff;
            end else if (req.req_type == OP_MFLO) begin
               rd_in = lo_ff;
            end else if (req.req_type == OP_MTHI) begin
               hi_in = req.operand_a;
            end else if (req.req_type == OP_MTLO) begin
               lo_in = req.operand_a;
            end else if (req.req_type[3] == 1'b0) begin
               state_in = ST_RUN;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_RUN: if (cnt_ff == '1) state_in = ST_FIX;
         ST_FIX: begin
            state_in = ST_OUT;
            unique case (op_ff)
               OP_MULT, OP_MULTU: begin
                  lo_in = sext32(prod[63:0]);
                  hi_in = sext32({32'd0, prod[63:32]});
               end
               OP_DMULT, OP_DMULTU: begin
                  lo_in = prod[63:0];
                  hi_in = prod[127:64];
               end
               OP_DIV: begin
                  if (b_ff == '0) begin
                     lo_in = a_ff[63] ? 64'd1 : '1;
                     hi_in = a_ff;
                  end else begin
                     lo_in = sext32(q);
                     hi_in = sext32(r);
                  end
               end
               OP_DIVU: begin
                  if (b_ff[31:0] == '0) begin
                     lo_in = '1;
                     hi_in = sext32(a_ff);
                  end else begin
                     lo_in = sext32(q);
                     hi_in = sext32(r);
                  end
               end
               OP_DDIV: begin
                  if (b_ff == '0) begin
                     lo_in = a_ff[63] ? 64'd1 : '1;
                     hi_in = a_ff;
                  end else begin
                     lo_in = q;
                     hi_in = r;
                  end
               end
               OP_DDIVU: begin
                  if (b_ff == '0) begin
                     lo_in = '1;
                     hi_in = a_ff;
                  end else begin
                     lo_in = q;
                     hi_in = r;
                  end
               end
               default: ;
            endcase
         end
         ST_OUT: if (rsp.ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         hi_ff <= '0;
         lo_ff <= '0;
         dw_ff <= 1'b1;
         cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         hi_ff <= hi_in;
         lo_ff <= lo_in;
         if (csr_psel && csr_penable && csr_pwrite && csr_pready
             && csr_paddr == RegDwordEnable) dw_ff <= csr_pwdata[0];
         cnt_ff <= (state_ff == ST_RUN) ? cnt_ff + 1'b1 : '0;
      end
   end

   always_ff @(posedge clock) begin
      rd_ff <= rd_in;
      flt_ff <= flt_in;
      if (acc) begin
         op_ff <= req.req_type;
         a_ff <= req.operand_a;
         b_ff <= req.operand_b;
         neg_p_ff <= (req.req_type == OP_MULT) ? (ra[63] ^ sb[63])
                     : (req.req_type == OP_DMULT) ? (ra[63] ^ rb[63]) : 1'b0;
         neg_q_ff <= (req.req_type == OP_DIV) ? (ra[31] ^ rb[63])
                     : (req.req_type == OP_DDIV) ? (ra[63] ^ rb[63]) : 1'b0;
         neg_r_ff <= (req.req_type == OP_DIV) ? ra[31]
                     : (req.req_type == OP_DDIV) ? ra[63] : 1'b0;
      end
   end
endmodule

/* src/mmd_checker.sv */
// port-level checker for the multiply/divide unit, bound to the top level
`include "mips_mul_div_hilo_unit_defines.svh"
module mmd_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [mmd_pkg::DataWidth-1:0] rsp_lo_value
);
   `MMD_ASSERT_IMPL(a_no_overlap, clock, reset, rsp_valid, !req_ready)
   `MMD_ASSERT_NEXT(a_accept_busy, clock, reset, req_valid && req_ready, !req_ready)
   `MMD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
                    rsp_valid && $stable(rsp_lo_value))
   `MMD_ASSERT_NEXT(a_idle_after, clock, reset, rsp_valid && rsp_ready, req_ready)
endmodule

bind mips_mul_div_hilo_unit mmd_checker u_checker (
   .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_lo_value(rsp.lo_value)
);
